>>> rtl/apis_pkg.sv
`timescale 1ns / 1ps

package apis_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic advance;
    logic set_res;
    logic res_val;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic bound_over;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

>>> rtl/apis_in_if.sv
`timescale 1ns / 1ps

interface apis_in_if import apis_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

>>> rtl/apis_out_if.sv
`timescale 1ns / 1ps

interface apis_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  logic any_prime;
  logic done_res;

  modport source (output valid, output is_prime, output any_prime, output done_res,
                  input ready);
  modport sink   (input valid, input is_prime, input any_prime, input done_res,
                  output ready);
endinterface

>>> rtl/any_prime_in_stream.sv
// Values settled without division (negative, below 2, 2, even, or 3..8) skip the
//   divider; others try odd divisors d in turn until one divides or d*d > v, each
//   on the single restoring divider that yields one remainder bit per cycle.
// Items are taken one at a time: the next is accepted once the last is emitted.
// Reset (rst, synchronous, active high): controller idle, output item dropped,
//   per-array prime flag cleared.
`timescale 1ns / 1ps

module any_prime_in_stream import apis_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  apis_in_if.sink   in_ch,
  apis_out_if.source out_ch
);

  // Controller sequences one item: TEST checks the trivial cases and the d*d > v
  // bound, DIV runs the remainder for the current odd divisor, NEXT stops on a
  // zero remainder, else moves to d+2 (d*d, alignment kept incrementally, no
  // multiplier or shifter), DONE waits for the output register to free up.
  cmd_t    cmd;
  status_t status;

  apis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds the operand, divisor state, remainder, and the output
  // register, so a finished item can wait while the next is accepted.
  apis_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (in_ch.value),
    .last      (in_ch.last),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .is_prime  (out_ch.is_prime),
    .any_prime (out_ch.any_prime),
    .done_res  (out_ch.done_res)
  );

endmodule

>>> rtl/apis_ctrl.sv
`timescale 1ns / 1ps

module apis_ctrl import apis_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (status.trivial || status.bound_over) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (status.rem_zero) state_next = ST_DONE;
        else state_next = ST_TEST;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_TEST: begin
        if (status.trivial) begin
          cmd.set_res = 1'b1;
          cmd.res_val = status.trivial_prime;
        end else if (status.bound_over) begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_NEXT: begin
        if (status.rem_zero) begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b0;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/apis_dp.sv
`timescale 1ns / 1ps

module apis_dp import apis_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  input  cmd_t                          cmd,
  output status_t                       status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_prime,
  output logic                          any_prime,
  output logic                          done_res
);

  localparam int W  = VALUE_WIDTH;
  localparam int SW = W + 1;
  localparam int KW = $clog2(W);

  logic [W-1:0]  v;
  logic          last_q;
  logic [W-1:0]  d;
  logic [SW-1:0] sq;
  logic [W-1:0]  top;       // 2^bitlen(d)
  logic [W-1:0]  base;      // d aligned to the top of the divide
  logic [W-1:0]  step;      // 2 at the same alignment
  logic [KW-1:0] kinit;     // alignment shift of base
  logic [KW-1:0] kcnt;
  logic [W-1:0]  r;
  logic [W-1:0]  sd;
  logic          res_prime;
  logic          prime_seen;

  logic [W-1:0]  d_plus;
  logic [W-1:0]  base_plus;
  logic          any_next;

  assign d_plus    = d + W'(2);
  assign base_plus = base + step;
  assign any_next  = prime_seen | res_prime;

  assign status.trivial       = v[W-1] | (v < W'(2)) | (v == W'(2)) | ~v[0];
  assign status.trivial_prime = (v == W'(2));
  assign status.bound_over    = (sq > {1'b0, v});
  assign status.div_last      = (kcnt == '0);
  assign status.rem_zero      = (r == '0);
  assign status.out_free      = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v      <= W'(unsigned'(value));
      last_q <= last;
      d      <= W'(3);
      sq     <= SW'(9);
      top    <= W'(4);
      kinit  <= KW'(W - 3);
      base   <= W'(3) << (W - 3);
      step   <= W'(2) << (W - 3);
    end
    if (cmd.start_div) begin
      r    <= v;
      sd   <= base;
      kcnt <= kinit;
    end
    // one restoring compare-subtract per cycle, remainder only
    if (cmd.div_step) begin
      if (r >= sd) r <= r - sd;
      sd   <= sd >> 1;
      kcnt <= kcnt - KW'(1);
    end
    if (cmd.advance) begin
      d  <= d_plus;
      sq <= sq + SW'({d, 2'b00}) + SW'(4);
      if (d_plus > top) begin
        top   <= top << 1;
        kinit <= kinit - KW'(1);
        base  <= base_plus >> 1;
        step  <= step >> 1;
      end else begin
        base <= base_plus;
      end
    end
    if (cmd.set_res) res_prime <= cmd.res_val;
    if (cmd.emit) begin
      is_prime  <= res_prime;
      any_prime <= any_next;
      done_res  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prime_seen <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        prime_seen <= last_q ? 1'b0 : any_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/apis_checker.sv
`timescale 1ns / 1ps

module apis_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_prime,
  input logic any_prime,
  input logic done_res
);

  // one item in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(is_prime) && $stable(any_prime) && $stable(done_res)))
    else $error("stalled output item changed");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_prime) |-> any_prime)
    else $error("prime item without any_prime");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind any_prime_in_stream apis_checker u_apis_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .is_prime  (out_ch.is_prime),
  .any_prime (out_ch.any_prime),
  .done_res  (out_ch.done_res)
);
